// ===== hdl/tcpq_pkg.sv =====
// Shared types, widths and codes for the two-class priority queue.
package tcpq_pkg;

    localparam int AGE_W     = 7;
    localparam int TAG_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 6;
    localparam int ENTRY_W   = AGE_W + 1 + TAG_W;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam int CLASS_DEPTH_DEF = 16;

    localparam logic [AGE_W-1:0] AGE_THRESHOLD_RST = 7'd60;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd3;

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic             flagged;
        logic [TAG_W-1:0] tag;
    } t_entry;

endpackage

// ===== hdl/two_class_priority_queue.sv =====
// Two-class strict-priority queue: two FIFOs, class picked at enqueue, priority served first.
// An accepted word is held in the accept stage, then in the result register that drives the master side.
// Throughput: one word per cycle unless stalled; a word moves at most one head or tail and count.
// Input stalls only while the accept stage holds a word blocked behind a waiting result.
// Reset (i_rst_n low, synchronous): both FIFOs empty, pointers zero, threshold 60.
// Entry memories are not cleared; the counts keep unwritten entries from being read.
module two_class_priority_queue #(
    parameter int CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: age_threshold
    input  logic                          i_cfg_wr_en,
    input  logic [tcpq_pkg::AGE_W-1:0]    i_cfg_wr_data,
    // slave side
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [tcpq_pkg::S_TDATA_W-1:0] i_s_axis_tdata, // age[6:0], flagged[7], person_tag[23:8]
    input  logic                          i_s_axis_tuser,   // op[0]
    // master side
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // out_age[6:0], out_flagged[7], out_tag[23:8], out_was_priority[24], occupancy[30:25], 0[31]
    output logic [tcpq_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    output logic [tcpq_pkg::STATUS_W-1:0]  o_m_axis_tuser   // status[1:0]
);

    import tcpq_pkg::*;

    localparam int PTR_W = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int CNT_W = $clog2(CLASS_DEPTH + 1);
    localparam int SUM_W0 = $clog2(2 * CLASS_DEPTH + 1);
    localparam int SUM_W = (SUM_W0 > OCC_W) ? SUM_W0 : OCC_W;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CLASS_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CLASS_DEPTH);

    // control state
    logic [AGE_W-1:0] r_threshold;
    logic [PTR_W-1:0] r_pri_head, r_pri_tail, r_nrm_head, r_nrm_tail;
    logic [PTR_W-1:0] n_pri_head, n_pri_tail, n_nrm_head, n_nrm_tail;
    logic [CNT_W-1:0] r_pri_cnt, r_nrm_cnt, n_pri_cnt, n_nrm_cnt;

    // memories and read registers
    t_entry r_pri_mem [CLASS_DEPTH];
    t_entry r_nrm_mem [CLASS_DEPTH];
    t_entry r_pri_rd, r_nrm_rd;

    // accept stage
    logic                r_s1_valid;
    logic [STATUS_W-1:0] r_s1_status, n_s1_status;
    logic                r_s1_pri, n_s1_pri;
    logic [OCC_W-1:0]    r_s1_occ;

    // result register
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_tdata;
    logic [STATUS_W-1:0]  r_out_status;

    logic   w_accept, w_s1_move;
    logic   w_op, w_is_pri, w_pri_wr, w_nrm_wr;
    t_entry w_entry, w_deq;
    logic [SUM_W-1:0] w_sum;

    assign w_s1_move       = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || w_s1_move;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_op          = i_s_axis_tuser;
    assign w_entry       = {i_s_axis_tdata[6:0], i_s_axis_tdata[7], i_s_axis_tdata[23:8]};
    assign w_is_pri      = (w_entry.age > r_threshold) || w_entry.flagged;

    always_comb begin
        n_pri_head  = r_pri_head;
        n_pri_tail  = r_pri_tail;
        n_nrm_head  = r_nrm_head;
        n_nrm_tail  = r_nrm_tail;
        n_pri_cnt   = r_pri_cnt;
        n_nrm_cnt   = r_nrm_cnt;
        n_s1_status = ST_EMPTY;
        n_s1_pri    = 1'b0;
        w_pri_wr    = 1'b0;
        w_nrm_wr    = 1'b0;
        if (w_op == OP_ENQ) begin
            if (w_is_pri) begin
                if (r_pri_cnt >= CNT_FULL) begin
                    n_s1_status = ST_DROPPED;
                end else begin
                    w_pri_wr    = 1'b1;
                    n_pri_tail  = (r_pri_tail == PTR_LAST) ? '0 : r_pri_tail + 1'b1;
                    n_pri_cnt   = r_pri_cnt + 1'b1;
                    n_s1_status = ST_ENQUEUED;
                end
            end else begin
                if (r_nrm_cnt >= CNT_FULL) begin
                    n_s1_status = ST_DROPPED;
                end else begin
                    w_nrm_wr    = 1'b1;
                    n_nrm_tail  = (r_nrm_tail == PTR_LAST) ? '0 : r_nrm_tail + 1'b1;
                    n_nrm_cnt   = r_nrm_cnt + 1'b1;
                    n_s1_status = ST_ENQUEUED;
                end
            end
        end else begin
            if (r_pri_cnt != '0) begin
                n_pri_head  = (r_pri_head == PTR_LAST) ? '0 : r_pri_head + 1'b1;
                n_pri_cnt   = r_pri_cnt - 1'b1;
                n_s1_pri    = 1'b1;
                n_s1_status = ST_DEQUEUED;
            end else if (r_nrm_cnt != '0) begin
                n_nrm_head  = (r_nrm_head == PTR_LAST) ? '0 : r_nrm_head + 1'b1;
                n_nrm_cnt   = r_nrm_cnt - 1'b1;
                n_s1_status = ST_DEQUEUED;
            end
        end
    end

    assign w_sum = SUM_W'(n_pri_cnt) + SUM_W'(n_nrm_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= AGE_THRESHOLD_RST;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pri_head <= '0;
            r_pri_tail <= '0;
            r_nrm_head <= '0;
            r_nrm_tail <= '0;
            r_pri_cnt  <= '0;
            r_nrm_cnt  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_pri_head <= n_pri_head;
                r_pri_tail <= n_pri_tail;
                r_nrm_head <= n_nrm_head;
                r_nrm_tail <= n_nrm_tail;
                r_pri_cnt  <= n_pri_cnt;
                r_nrm_cnt  <= n_nrm_cnt;
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= n_s1_status;
            r_s1_pri    <= n_s1_pri;
            r_s1_occ    <= w_sum[OCC_W-1:0];
        end
    end

    // entry memories: head read is registered with the accept
    always_ff @(posedge i_clk) begin
        if (w_accept && w_pri_wr) begin
            r_pri_mem[r_pri_tail] <= w_entry;
        end
        if (w_accept) begin
            r_pri_rd <= r_pri_mem[r_pri_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_nrm_wr) begin
            r_nrm_mem[r_nrm_tail] <= w_entry;
        end
        if (w_accept) begin
            r_nrm_rd <= r_nrm_mem[r_nrm_head];
        end
    end

    // data fields read zero unless a word was actually dequeued
    assign w_deq = (r_s1_status != ST_DEQUEUED) ? '0 : (r_s1_pri ? r_pri_rd : r_nrm_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_status <= r_s1_status;
            r_out_tdata  <= {1'b0, r_s1_occ, r_s1_pri, w_deq.tag, w_deq.flagged, w_deq.age};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_status;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pri_cnt <= CNT_FULL) && (r_nrm_cnt <= CNT_FULL))
        else $error("class count above depth");

    a_deq_pri_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_DEQ && r_pri_cnt != '0) |=>
        (r_pri_cnt == $past(r_pri_cnt) - 1'b1) && $stable(r_nrm_cnt) && r_s1_pri)
        else $error("dequeue did not serve the priority class");

    a_deq_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_DEQ && r_pri_cnt == '0 && r_nrm_cnt == '0) |=>
        (r_s1_status == ST_EMPTY) && $stable(r_pri_head) && $stable(r_nrm_head))
        else $error("dequeue of empty queue changed state");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_ENQ && w_is_pri && r_pri_cnt >= CNT_FULL) |=>
        (r_s1_status == ST_DROPPED) && $stable(r_pri_cnt) && $stable(r_pri_tail))
        else $error("full priority class did not drop the word");
`endif

endmodule
